@@ rtl/mid_pkg.sv @@
// Shared types, constants and register map of the motion and idle detector.
package mid_pkg;

	localparam int CAL_SAMPLES = 100;
	localparam int CNT_W       = 10;
	localparam int SUM_W       = 17;
	localparam int CAL_W       = $clog2(CAL_SAMPLES + 1);
	localparam int DIFF_W      = SUM_W + 2;
	localparam int RUN_W       = 3;
	localparam int LEVEL_W     = 9;
	localparam int WIN_W       = 16;
	localparam int NUM_AXES    = 3;
	localparam int AXIS_X      = 0;
	localparam int AXIS_Y      = 1;
	localparam int AXIS_Z      = 2;

	localparam logic signed [DIFF_W-1:0] CAL_SCALE = DIFF_W'(CAL_SAMPLES);
	localparam logic [CAL_W-1:0]         CAL_LAST  = CAL_W'(CAL_SAMPLES);
	localparam logic [RUN_W-1:0]         RUN_MAX   = '1;

	typedef enum logic [1:0] {
		REG_SCRAMBLE_LEVEL = 2'd0,
		REG_SOLVE_LEVEL    = 2'd1,
		REG_WINDOW_HALF    = 2'd2,
		REG_IDLE_SAMPLES   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] scramble_level;
		logic [LEVEL_W-1:0] solve_level;
		logic [WIN_W-1:0]   window_half_scaled;
		logic [RUN_W-1:0]   idle_samples;
	} cfg_t;

	typedef struct packed {
		logic signed [CNT_W-1:0] counts;
		logic                    in_win;
	} lane_res_t;

	typedef struct packed {
		logic calibrating;
		logic idle;
		logic scramble;
		logic solved;
	} flags_t;

endpackage

@@ rtl/mid_cfg.sv @@
// APB register bank holding the detector levels, window and run length.
module mid_cfg
	import mid_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scramble_level     <= LEVEL_W'(500);
			cfg_q.solve_level        <= LEVEL_W'(508);
			cfg_q.window_half_scaled <= WIN_W'(1250);
			cfg_q.idle_samples       <= RUN_W'(5);
		end else if (wr) begin
			unique case (idx)
				REG_SCRAMBLE_LEVEL: cfg_q.scramble_level     <= pwdata[LEVEL_W-1:0];
				REG_SOLVE_LEVEL:    cfg_q.solve_level        <= pwdata[LEVEL_W-1:0];
				REG_WINDOW_HALF:    cfg_q.window_half_scaled <= pwdata[WIN_W-1:0];
				REG_IDLE_SAMPLES:   cfg_q.idle_samples       <= pwdata[RUN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SCRAMBLE_LEVEL: prdata = 32'(cfg_q.scramble_level);
			REG_SOLVE_LEVEL:    prdata = 32'(cfg_q.solve_level);
			REG_WINDOW_HALF:    prdata = 32'(cfg_q.window_half_scaled);
			REG_IDLE_SAMPLES:   prdata = 32'(cfg_q.idle_samples);
			default:            prdata = '0;
		endcase
	end

endmodule

@@ rtl/mid_lane.sv @@
// One axis lane: count assembly, calibration sum and window test.
module mid_lane
	import mid_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             cal,
	input  logic [7:0]       data_low,
	input  logic [7:0]       data_high,
	input  logic [WIN_W-1:0] window_half_scaled,
	output lane_res_t        res
);

	logic signed [SUM_W-1:0]  sum_q;
	logic signed [CNT_W-1:0]  counts;
	logic signed [DIFF_W-1:0] prod;
	logic signed [DIFF_W-1:0] diff;
	logic        [DIFF_W-1:0] mag;

	// the two high bits and the low byte already form a two's complement count
	assign counts = {data_high[1:0], data_low};

	assign prod = DIFF_W'(counts) * CAL_SCALE;
	assign diff = prod - DIFF_W'(sum_q);
	assign mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

	assign res.counts = counts;
	assign res.in_win = (mag <= DIFF_W'(window_half_scaled));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (accept && cal) begin
			sum_q <= sum_q + SUM_W'(counts);
		end
	end

endmodule

@@ rtl/mid_merge.sv @@
// Merges the lane results into the calibration count, run counter and flags.
module mid_merge
	import mid_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  cfg_t      cfg,
	input  lane_res_t lanes [NUM_AXES],
	output logic      cal,
	output flags_t    flags
);

	logic [CAL_W-1:0] cal_cnt_q;
	logic [RUN_W-1:0] run_q;
	logic [RUN_W-1:0] run_nx;
	logic [RUN_W-1:0] run_inc;
	logic             idle_q, scramble_q, solve_q;
	logic             idle_nx, scramble_nx, solve_nx;
	logic             win_all;
	logic             z_hit, x_hit;

	assign cal     = (cal_cnt_q < CAL_LAST);
	assign win_all = lanes[AXIS_X].in_win & lanes[AXIS_Y].in_win & lanes[AXIS_Z].in_win;
	assign z_hit   = $signed({lanes[AXIS_Z].counts[CNT_W-1], lanes[AXIS_Z].counts})
	                 >= $signed({2'b00, cfg.scramble_level});
	assign x_hit   = $signed({lanes[AXIS_X].counts[CNT_W-1], lanes[AXIS_X].counts})
	                 >= $signed({2'b00, cfg.solve_level});
	assign run_inc = (run_q < RUN_MAX) ? run_q + RUN_W'(1) : run_q;

	always_comb begin
		run_nx      = run_q;
		idle_nx     = idle_q;
		scramble_nx = scramble_q;
		solve_nx    = solve_q;
		if (!cal) begin
			scramble_nx = scramble_q | z_hit;
			solve_nx    = solve_q | x_hit;
			if (win_all) begin
				run_nx  = run_inc;
				idle_nx = idle_q | (run_inc >= cfg.idle_samples);
			end else begin
				// leaving the window drops idle at once
				run_nx  = '0;
				idle_nx = 1'b0;
			end
		end
	end

	assign flags.calibrating = cal;
	assign flags.idle        = idle_nx;
	assign flags.scramble    = scramble_nx;
	assign flags.solved      = solve_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_cnt_q  <= '0;
			run_q      <= '0;
			idle_q     <= 1'b0;
			scramble_q <= 1'b0;
			solve_q    <= 1'b0;
		end else if (accept) begin
			if (cal) begin
				cal_cnt_q <= cal_cnt_q + CAL_W'(1);
			end
			run_q      <= run_nx;
			idle_q     <= idle_nx;
			scramble_q <= scramble_nx;
			solve_q    <= solve_nx;
		end
	end

endmodule

@@ rtl/accel_motion_idle_detector.sv @@
// Top level of the accelerometer motion and idle detector.
// Takes one three-axis sample per transaction and returns one result per sample,
// one sample per clock cycle when the output side is not stalled; each result
// appears in the output register in the cycle after its sample is accepted. The
// three axes run in parallel lanes that each hold a calibration sum and test the
// window with a constant multiply, subtract and compare; a merge stage updates
// the run counter and flags. The first 100 samples after reset only calibrate.
// Registers: 0x0 scramble level, 0x4 solve level, 0x8 window half-width
// times the calibration count, 0xC idle run length; write only while idle.
module accel_motion_idle_detector
	import mid_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [3:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [7:0]              x_low,
	input  logic [7:0]              x_high,
	input  logic [7:0]              y_low,
	input  logic [7:0]              y_high,
	input  logic [7:0]              z_low,
	input  logic [7:0]              z_high,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [CNT_W-1:0] x_counts,
	output logic signed [CNT_W-1:0] y_counts,
	output logic signed [CNT_W-1:0] z_counts,
	output logic                    calibrating,
	output logic                    idle_out,
	output logic                    scramble_out,
	output logic                    solve_out
);

	cfg_t       cfg;
	lane_res_t  lanes [NUM_AXES];
	logic [7:0] lows  [NUM_AXES];
	logic [7:0] highs [NUM_AXES];
	logic       accept;
	logic       cal;
	flags_t     flags;

	logic                    out_valid_q;
	logic signed [CNT_W-1:0] x_q, y_q, z_q;
	flags_t                  flags_q;

	// take a new transaction whenever the output register is free or draining
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	assign lows[AXIS_X]  = x_low;
	assign lows[AXIS_Y]  = y_low;
	assign lows[AXIS_Z]  = z_low;
	assign highs[AXIS_X] = x_high;
	assign highs[AXIS_Y] = y_high;
	assign highs[AXIS_Z] = z_high;

	mid_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
		mid_lane u_lane (
			.clk                (clk),
			.arst_n             (arst_n),
			.accept             (accept),
			.cal                (cal),
			.data_low           (lows[a]),
			.data_high          (highs[a]),
			.window_half_scaled (cfg.window_half_scaled),
			.res                (lanes[a])
		);
	end

	mid_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.cfg    (cfg),
		.lanes  (lanes),
		.cal    (cal),
		.flags  (flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q     <= lanes[AXIS_X].counts;
			y_q     <= lanes[AXIS_Y].counts;
			z_q     <= lanes[AXIS_Z].counts;
			flags_q <= flags;
		end
	end

	assign out_valid    = out_valid_q;
	assign x_counts     = x_q;
	assign y_counts     = y_q;
	assign z_counts     = z_q;
	assign calibrating  = flags_q.calibrating;
	assign idle_out     = flags_q.idle;
	assign scramble_out = flags_q.scramble;
	assign solve_out    = flags_q.solved;

endmodule

@@ test/accel_motion_idle_detector_tb.sv @@
// Self-checking testbench for the accelerometer motion and idle detector.
module accel_motion_idle_detector_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mid_pkg::*;

	localparam int CNT_MIN = -512;
	localparam int CNT_MAX = 511;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PATTERN
	} stall_mode_t;

	// Tracks the detector state and checks each output reading in order.
	class motion_scoreboard;
		typedef struct {
			logic signed [CNT_W-1:0] x;
			logic signed [CNT_W-1:0] y;
			logic signed [CNT_W-1:0] z;
			flags_t                  flags;
		} reading_t;

		reading_t                pending_readings[$];
		cfg_t                    cfg;
		logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
		logic [CAL_W-1:0]        cal_taken;
		logic [RUN_W-1:0]        still_run;
		logic                    idle_flag, scramble_flag, solve_flag;
		int                      failures;

		function new();
			cfg.scramble_level     = LEVEL_W'(500);
			cfg.solve_level        = LEVEL_W'(508);
			cfg.window_half_scaled = WIN_W'(1250);
			cfg.idle_samples       = RUN_W'(5);
			sum_x = '0;
			sum_y = '0;
			sum_z = '0;
			cal_taken = '0;
			still_run = '0;
			idle_flag = 1'b0;
			scramble_flag = 1'b0;
			solve_flag = 1'b0;
			failures = 0;
		endfunction

		function void set_register(reg_idx_t idx, logic [31:0] v);
			case (idx)
			REG_SCRAMBLE_LEVEL: cfg.scramble_level = v[LEVEL_W-1:0];
			REG_SOLVE_LEVEL:    cfg.solve_level = v[LEVEL_W-1:0];
			REG_WINDOW_HALF:    cfg.window_half_scaled = v[WIN_W-1:0];
			default:            cfg.idle_samples = v[RUN_W-1:0];
			endcase
		endfunction

		function logic [31:0] register_value(reg_idx_t idx);
			case (idx)
			REG_SCRAMBLE_LEVEL: return 32'(cfg.scramble_level);
			REG_SOLVE_LEVEL:    return 32'(cfg.solve_level);
			REG_WINDOW_HALF:    return 32'(cfg.window_half_scaled);
			default:            return 32'(cfg.idle_samples);
			endcase
		endfunction

		function bit near_mean(logic signed [CNT_W-1:0] c, logic signed [SUM_W-1:0] s);
			int d;
			d = int'(c) * CAL_SAMPLES - int'(s);
			if (d < 0)
				d = -d;
			return d <= int'(cfg.window_half_scaled);
		endfunction

		function int pending_count();
			return pending_readings.size();
		endfunction

		function void note_sample(logic [7:0] xl, logic [7:0] xh, logic [7:0] yl,
				logic [7:0] yh, logic [7:0] zl, logic [7:0] zh);
			reading_t r;
			r.x = {xh[1:0], xl};
			r.y = {yh[1:0], yl};
			r.z = {zh[1:0], zl};
			r.flags.calibrating = int'(cal_taken) < CAL_SAMPLES;
			if (r.flags.calibrating) begin
				sum_x = sum_x + r.x;
				sum_y = sum_y + r.y;
				sum_z = sum_z + r.z;
				cal_taken = cal_taken + 1'b1;
			end else begin
				if (int'(r.z) >= int'(cfg.scramble_level))
					scramble_flag = 1'b1;
				if (int'(r.x) >= int'(cfg.solve_level))
					solve_flag = 1'b1;
				if (near_mean(r.x, sum_x) && near_mean(r.y, sum_y) && near_mean(r.z, sum_z)) begin
					// saturate the run length
					if (still_run != RUN_MAX)
						still_run = still_run + 1'b1;
					if (still_run >= cfg.idle_samples)
						idle_flag = 1'b1;
				end else begin
					idle_flag = 1'b0;
					still_run = '0;
				end
			end
			r.flags.idle = idle_flag;
			r.flags.scramble = scramble_flag;
			r.flags.solved = solve_flag;
			pending_readings.push_back(r);
		endfunction

		function void compare_field(string name, logic signed [CNT_W-1:0] want,
				logic signed [CNT_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				failures++;
			end
		endfunction

		function void check_result(logic signed [CNT_W-1:0] x, logic signed [CNT_W-1:0] y,
				logic signed [CNT_W-1:0] z, flags_t f);
			reading_t e;
			if (pending_readings.size() == 0) begin
				$error("result transaction with no sample pending");
				failures++;
				return;
			end
			e = pending_readings.pop_front();
			compare_field("x_counts", e.x, x);
			compare_field("y_counts", e.y, y);
			compare_field("z_counts", e.z, z);
			compare_field("calibrating", e.flags.calibrating, f.calibrating);
			compare_field("idle_out", e.flags.idle, f.idle);
			compare_field("scramble_out", e.flags.scramble, f.scramble);
			compare_field("solve_out", e.flags.solved, f.solved);
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b1;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [3:0]              paddr = '0;
	logic [31:0]             pwdata = '0;
	logic [31:0]             prdata;
	logic                    pready;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [7:0]              x_low = '0;
	logic [7:0]              x_high = '0;
	logic [7:0]              y_low = '0;
	logic [7:0]              y_high = '0;
	logic [7:0]              z_low = '0;
	logic [7:0]              z_high = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [CNT_W-1:0] x_counts;
	logic signed [CNT_W-1:0] y_counts;
	logic signed [CNT_W-1:0] z_counts;
	logic                    calibrating;
	logic                    idle_out;
	logic                    scramble_out;
	logic                    solve_out;

	motion_scoreboard sb;
	stall_mode_t      stall_mode = STALL_NONE;
	int unsigned      stall_tick = 0;
	int               burst_left = 20;
	int               sum_sent_x = 0;
	int               sum_sent_y = 0;
	int               sum_sent_z = 0;
	int               bx, by, bz;

	accel_motion_idle_detector u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.x_low        (x_low),
		.x_high       (x_high),
		.y_low        (y_low),
		.y_high       (y_high),
		.z_low        (z_low),
		.z_high       (z_high),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.x_counts     (x_counts),
		.y_counts     (y_counts),
		.z_counts     (z_counts),
		.calibrating  (calibrating),
		.idle_out     (idle_out),
		.scramble_out (scramble_out),
		.solve_out    (solve_out)
	);

	always #1 clk = ~clk;

	// Receiver back-pressure: pick a new stall pattern whenever the low seven tick bits are zero.
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (stall_tick[6:0] == 7'd0)
			stall_mode <= stall_mode_t'($urandom_range(3));
		case (stall_mode)
		STALL_NONE:  out_stall <= 1'b0;
		STALL_LIGHT: out_stall <= ($urandom_range(99) < 30);
		STALL_HEAVY: out_stall <= ($urandom_range(99) < 75);
		default:     out_stall <= (stall_tick % 5 < 2);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(x_counts, y_counts, z_counts,
				flags_t'({calibrating, idle_out, scramble_out, solve_out}));
	end

	function automatic int clamp_count(int v);
		return (v < CNT_MIN) ? CNT_MIN : (v > CNT_MAX) ? CNT_MAX : v;
	endfunction

	function automatic int rand_offset(int w);
		return int'($urandom_range(2 * w)) - w;
	endfunction

	task automatic send_counts(int x, int y, int z);
		logic [9:0] cx, cy, cz;
		cx = 10'(x);
		cy = 10'(y);
		cz = 10'(z);
		// fill the unused high bits with noise
		x_low <= cx[7:0];
		x_high <= {6'($urandom), cx[9:8]};
		y_low <= cy[7:0];
		y_high <= {6'($urandom), cy[9:8]};
		z_low <= cz[7:0];
		z_high <= {6'($urandom), cz[9:8]};
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_sample(x_low, x_high, y_low, y_high, z_low, z_high);
		sum_sent_x += x;
		sum_sent_y += y;
		sum_sent_z += z;
	endtask

	task automatic pace_sender();
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 40);
		end
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending_count() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(reg_idx_t idx, logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_register(idx, v);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read_check(reg_idx_t idx);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== sb.register_value(idx)) begin
			$error("prdata %s: expected %0d, got %0d", idx.name(), sb.register_value(idx), prdata);
			sb.failures++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_all_registers();
		apb_read_check(REG_SCRAMBLE_LEVEL);
		apb_read_check(REG_SOLVE_LEVEL);
		apb_read_check(REG_WINDOW_HALF);
		apb_read_check(REG_IDLE_SAMPLES);
	endtask

	task automatic apply_settings(int scr, int sol, int win, int idl);
		wait_results_drained();
		apb_write(REG_SCRAMBLE_LEVEL, 32'(scr));
		apb_write(REG_SOLVE_LEVEL, 32'(sol));
		apb_write(REG_WINDOW_HALF, 32'(win));
		apb_write(REG_IDLE_SAMPLES, 32'(idl));
		read_all_registers();
	endtask

	task automatic send_random_sample(int w);
		int r, ox, oy, oz;
		r = $urandom_range(99);
		if (r >= 85) begin
			send_counts($urandom_range(1023) - 512, $urandom_range(1023) - 512,
				$urandom_range(1023) - 512);
			return;
		end
		if (r < 55 || r >= 75) begin
			ox = rand_offset(w);
			oy = rand_offset(w);
			oz = rand_offset(w);
		end else begin
			ox = rand_offset(w + 2);
			oy = rand_offset(w + 2);
			oz = rand_offset(w + 2);
		end
		// push one axis just past the window edge
		if (r >= 75) begin
			case ($urandom_range(2))
			0: ox = $urandom_range(1) ? w + 1 : -(w + 1);
			1: oy = $urandom_range(1) ? w + 1 : -(w + 1);
			default: oz = $urandom_range(1) ? w + 1 : -(w + 1);
			endcase
		end
		send_counts(clamp_count(bx + ox), clamp_count(by + oy), clamp_count(bz + oz));
	endtask

	initial begin
		#2_000_000;
		$display("accel_motion_idle_detector_tb: done, errors");
		$finish;
	end

	initial begin
		int scr, sol, win, idl;
		arst_n <= 1'b0;
		sb = new();
		bx = int'($urandom_range(40)) - 20;
		by = int'($urandom_range(40)) - 20;
		bz = 200 + int'($urandom_range(60));
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		read_all_registers();

		// calibration: extremes first, then samples near the chosen mean
		send_counts(CNT_MIN, CNT_MAX, -1);
		send_counts(CNT_MAX, CNT_MIN, 0);
		send_counts(0, -1, CNT_MAX);
		send_counts(-1, 0, CNT_MIN);
		for (int i = 0; i < CAL_SAMPLES - 8; i++) begin
			send_counts(bx + rand_offset(3), by + rand_offset(3), bz + rand_offset(3));
			pace_sender();
		end
		// steer the sums so the mean lands on a whole count
		for (int i = 4; i > 0; i--)
			send_counts(clamp_count(bx + (CAL_SAMPLES * bx - sum_sent_x) / i),
				clamp_count(by + (CAL_SAMPLES * by - sum_sent_y) / i),
				clamp_count(bz + (CAL_SAMPLES * bz - sum_sent_z) / i));

		// reset settings: idle run, negative counts below the levels, window edge, latches
		repeat (6) send_counts(bx, by, bz);
		send_counts(CNT_MIN, by, CNT_MIN);
		send_counts(507, by, 499);
		repeat (2) send_counts(bx + 12, by - 12, bz + 12);
		send_counts(bx + 13, by, bz);
		send_counts(bx, by, 500);
		send_counts(508, by, bz);
		send_counts(CNT_MAX, CNT_MIN, CNT_MAX);
		send_counts(bx, by, bz);

		for (int p = 0; p < 10; p++) begin
			case (p)
			0: begin scr = 0;   sol = 511; win = 0;     idl = 0; end
			1: begin scr = 511; sol = 0;   win = 100;   idl = 1; end
			2: begin scr = 511; sol = 511; win = 99;    idl = 7; end
			3: begin scr = 0;   sol = 0;   win = 65535; idl = 7; end
			4: begin scr = 255; sol = 256; win = 51200; idl = 3; end
			5: begin scr = 500; sol = 508; win = 350;   idl = 2; end
			default: begin
				scr = $urandom_range(511);
				sol = $urandom_range(511);
				win = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(2000);
				idl = $urandom_range(7);
			end
			endcase
			apply_settings(scr, sol, win, idl);
			for (int i = 0; i < 125; i++) begin
				send_random_sample(win / CAL_SAMPLES);
				pace_sender();
				// hold the sender until every result is back
				if (p == 4 && i == 60)
					wait_results_drained();
			end
		end

		wait_results_drained();
		if (sb.failures == 0)
			$display("accel_motion_idle_detector_tb: done, clean");
		else
			$display("accel_motion_idle_detector_tb: done, errors");
		$finish;
	end

endmodule
